[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fdm_pkg.sv]
package fdm_pkg;

  localparam int unsigned TrackW  = 7;
  localparam int unsigned TypeW   = 4;
  localparam int unsigned FlagW   = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SelW    = 2;

  // capability flag bit positions
  localparam int unsigned FRpm300 = 0;
  localparam int unsigned FRpm360 = 1;
  localparam int unsigned F525    = 2;
  localparam int unsigned FDs     = 3;
  localparam int unsigned FHoleDd = 4;
  localparam int unsigned FHoleHd = 5;
  localparam int unsigned FHoleEd = 6;
  localparam int unsigned FDstep  = 7;
  localparam int unsigned FInvDen = 8;

  typedef enum logic [2:0] {
    CMD_STEP    = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_HEAD    = 3'd2,
    CMD_DENSITY = 3'd3,
    CMD_STATUS  = 3'd4
  } fdm_cmd_e;

  typedef enum logic [1:0] {
    HOLE_DD  = 2'd0,
    HOLE_HD  = 2'd1,
    HOLE_ED  = 2'd2,
    HOLE_BAD = 2'd3
  } fdm_hole_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [SelW-1:0]   drive_sel;
    logic signed [7:0] track_step;
    logic              head_value;
    logic              density_value;
    logic [1:0]        media_hole;
  } fdm_in_t;

  typedef struct packed {
    logic [TrackW-1:0] track_now;
    logic              at_track_zero;
    logic              head_now;
    logic              speed_360;
    logic              medium_readable;
    logic              double_step;
    logic              drive_density;
    logic              disk_changed;
  } fdm_out_t;

  typedef struct packed {
    logic [TrackW-1:0] last_track;
    logic [FlagW-1:0]  flags;
  } fdm_type_t;

  // drive state after the current item, one drive
  typedef struct packed {
    logic [TrackW-1:0] track;
    logic              head;
    logic              changed;
    fdm_type_t         dtype;
  } fdm_drv_t;

  function automatic fdm_type_t fdm_type_lookup(input logic [TypeW-1:0] idx);
    fdm_type_t t;
    case (idx)
      4'd1:    t = '{last_track: 7'd43, flags: 9'h015};
      4'd2:    t = '{last_track: 7'd43, flags: 9'h01D};
      4'd3:    t = '{last_track: 7'd86, flags: 9'h09D};
      4'd4:    t = '{last_track: 7'd86, flags: 9'h1BE};
      4'd5:    t = '{last_track: 7'd86, flags: 9'h0BE};
      4'd6:    t = '{last_track: 7'd86, flags: 9'h0BF};
      4'd7:    t = '{last_track: 7'd86, flags: 9'h091};
      4'd8:    t = '{last_track: 7'd86, flags: 9'h099};
      4'd9:    t = '{last_track: 7'd86, flags: 9'h1B9};
      4'd10:   t = '{last_track: 7'd86, flags: 9'h0B9};
      4'd11:   t = '{last_track: 7'd86, flags: 9'h1BB};
      4'd12:   t = '{last_track: 7'd86, flags: 9'h0BB};
      4'd13:   t = '{last_track: 7'd86, flags: 9'h0F9};
      default: t = '{last_track: 7'd0,  flags: 9'h000};
    endcase
    return t;
  endfunction

endpackage

[rtl/floppy_drive_mechanism.sv]
// The result of an accepted item is registered and is shown in the cycle after it is accepted.
// Throughput: one item per cycle while in_stall_o is low; all update and status
// logic sits between the per-drive state registers and the single result register.
// in_stall_o rises only while a finished result waits on out_stall_i.
// Reset (rst_ni low, async): all tracks, heads, changed flags, density and types 0.
module floppy_drive_mechanism #(
  parameter int unsigned NUM_DRIVES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fdm_pkg::fdm_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fdm_pkg::fdm_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fdm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fdm_pkg::TypeW-1:0]     cfg_data_i
);
  import fdm_pkg::*;

  logic      in_acc;
  logic      raw_den_q, raw_den_d;
  logic      out_valid_q;
  fdm_out_t  out_q, res_d;
  fdm_drv_t  drv [NUM_DRIVES];
  fdm_drv_t  sel_drv;
  logic      sel_ok;
  logic [FlagW-1:0] fl;

  // Input beat taken when the output slot is free or draining this cycle.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Density select is shared; it follows set density even for absent drives.
  assign raw_den_d = (in_data_i.command == CMD_DENSITY) ? in_data_i.density_value
                                                        : raw_den_q;

  for (genvar i = 0; i < NUM_DRIVES; i++) begin : g_drv
    logic hit;
    assign hit = (in_data_i.drive_sel == SelW'(i));
    fdm_drive u_drive (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_we_i   (cfg_valid_i && (cfg_index_i == CfgIdxW'(i))),
      .cfg_type_i (cfg_data_i),
      .upd_en_i   (in_acc && hit),
      .item_i     (in_data_i),
      .drv_o      (drv[i])
    );
  end

  // Select the addressed drive's post-update state; no match means absent drive.
  always_comb begin
    sel_drv = '0;
    sel_ok  = 1'b0;
    for (int i = 0; i < NUM_DRIVES; i++) begin
      if (in_data_i.drive_sel == SelW'(i)) begin
        sel_drv = drv[i];
        sel_ok  = 1'b1;
      end
    end
  end

  assign fl = sel_drv.dtype.flags;

  always_comb begin
    res_d = '0;
    if (sel_ok) begin
      res_d.track_now     = sel_drv.track;
      res_d.at_track_zero = (sel_drv.dtype.last_track != '0) && (sel_drv.track == '0);
      res_d.head_now      = sel_drv.head & fl[FDs];
      // spindle: fixed-speed types first, then the two dual-rpm flavors
      if (!fl[FRpm360]) begin
        res_d.speed_360 = 1'b0;
      end else if (!fl[FRpm300]) begin
        res_d.speed_360 = 1'b1;
      end else if (fl[F525]) begin
        res_d.speed_360 = raw_den_d;
      end else begin
        res_d.speed_360 = (in_data_i.media_hole == HOLE_HD) && !raw_den_d;
      end
      case (in_data_i.media_hole)
        HOLE_DD: res_d.medium_readable = fl[FHoleDd];
        HOLE_HD: res_d.medium_readable = fl[FHoleHd];
        HOLE_ED: res_d.medium_readable = fl[FHoleEd];
        default: res_d.medium_readable = 1'b0;
      endcase
      res_d.double_step   = fl[FDstep];
      res_d.drive_density = raw_den_d ^ fl[FInvDen];
      res_d.disk_changed  = sel_drv.changed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_den_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        raw_den_q <= raw_den_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "assert_macros.svh"

  `FDM_ASSERT_NXT(a_acc_gives_beat, in_acc, out_valid_o, "accepted item produced no result")
  `FDM_ASSERT_NOW(a_track_range, out_valid_o, out_data_o.track_now <= 7'd86, "track above 86")
  `FDM_ASSERT_NOW(a_trk0_consistent, out_valid_o && out_data_o.at_track_zero,
                  out_data_o.track_now == '0, "track-0 flag with nonzero track")
  `FDM_ASSERT_NXT(a_density_set, in_acc && in_data_i.command == CMD_DENSITY,
                  raw_den_q == $past(in_data_i.density_value), "density select not latched")

endmodule

[rtl/fdm_drive.sv]
module fdm_drive (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fdm_pkg::TypeW-1:0]    cfg_type_i,
  input  logic                         upd_en_i,
  input  fdm_pkg::fdm_in_t             item_i,
  output fdm_pkg::fdm_drv_t            drv_o
);
  import fdm_pkg::*;

  logic [TypeW-1:0]  type_q;
  logic [TrackW-1:0] track_q, track_d;
  logic              head_q, head_d;
  logic              chg_q, chg_d;
  fdm_type_t         ty;
  logic [8:0]        sum;
  logic [TrackW-1:0] clamped;

  assign ty  = fdm_type_lookup(type_q);
  // 9-bit two's complement: -128..213
  assign sum = {2'b00, track_q} + {item_i.track_step[7], item_i.track_step};

  always_comb begin
    if (sum[8]) begin
      clamped = '0;
    end else if (sum[7:0] > {1'b0, ty.last_track}) begin
      clamped = ty.last_track;
    end else begin
      clamped = sum[TrackW-1:0];
    end
  end

  always_comb begin
    track_d = track_q;
    head_d  = head_q;
    chg_d   = chg_q;
    case (item_i.command)
      CMD_STEP: begin
        if (item_i.track_step != 8'sd0) begin
          track_d = clamped;
          chg_d   = 1'b0;
        end
      end
      CMD_INSERT: begin
        track_d = (track_q > ty.last_track) ? ty.last_track : track_q;
        chg_d   = 1'b1;
      end
      CMD_HEAD: begin
        head_d = item_i.head_value & ty.flags[FDs];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q  <= '0;
      track_q <= '0;
      head_q  <= 1'b0;
      chg_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        type_q <= cfg_type_i;
      end
      if (upd_en_i) begin
        track_q <= track_d;
        head_q  <= head_d;
        chg_q   <= chg_d;
      end
    end
  end

  assign drv_o = '{track: track_d, head: head_d, changed: chg_d, dtype: ty};

endmodule

[test/floppy_drive_mechanism_tb.sv]
module floppy_drive_mechanism_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdm_pkg::*;

  localparam int NumDrives = 4;

  // config register map
  localparam logic [CfgIdxW-1:0] REG_TYPE_A = 2'd0, REG_TYPE_B = 2'd1,
                                 REG_TYPE_C = 2'd2, REG_TYPE_D = 2'd3;

  localparam logic [SelW-1:0] DRV_A = 2'd0, DRV_B = 2'd1, DRV_C = 2'd2, DRV_D = 2'd3;

  // drive type codes
  localparam logic [TypeW-1:0]
    TY_NONE        = 4'd0,  TY_525_1DD     = 4'd1,  TY_525_2DD  = 4'd2,
    TY_525_2QD     = 4'd3,  TY_525_HD_INV  = 4'd4,  TY_525_HD   = 4'd5,
    TY_525_HD_DUAL = 4'd6,  TY_35_1DD      = 4'd7,  TY_35_2DD   = 4'd8,
    TY_35_HD_INV   = 4'd9,  TY_35_HD       = 4'd10, TY_35_HD_INV_DUAL = 4'd11,
    TY_35_3MODE    = 4'd12, TY_35_ED       = 4'd13, TY_SPARE_14 = 4'd14,
    TY_SPARE_15    = 4'd15;

  // command codes the package enum leaves out; they read back status only
  localparam logic [2:0] CMD_SPARE_5 = 3'd5, CMD_SPARE_6 = 3'd6, CMD_SPARE_7 = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  fdm_in_t   in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  fdm_out_t  out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [TypeW-1:0]   cfg_data_i;

  floppy_drive_mechanism #(.NUM_DRIVES(NumDrives)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Mirror of the mechanism: per-drive head track, head select, changed flag,
  // the shared density line and the four type registers.
  // ---------------------------------------------------------------------------
  logic [TrackW-1:0] mirror_track [NumDrives];
  logic              mirror_head  [NumDrives];
  logic              mirror_chg   [NumDrives];
  logic [TypeW-1:0]  mirror_type  [4];
  logic              mirror_den;

  fdm_out_t pending_status [$];   // status beats the DUT still owes us
  int       mismatches = 0;
  bit       quiet      = 1'b0;    // no idling on either side while set

  // Capability row of a drive type: {max track, flags}. Codes 14/15 look like
  // an empty bay.
  function automatic logic [TrackW+FlagW-1:0] type_caps(input logic [TypeW-1:0] ty);
    case (ty)
      TY_525_1DD:        return {7'd43, 9'h015};
      TY_525_2DD:        return {7'd43, 9'h01D};
      TY_525_2QD:        return {7'd86, 9'h09D};
      TY_525_HD_INV:     return {7'd86, 9'h1BE};
      TY_525_HD:         return {7'd86, 9'h0BE};
      TY_525_HD_DUAL:    return {7'd86, 9'h0BF};
      TY_35_1DD:         return {7'd86, 9'h091};
      TY_35_2DD:         return {7'd86, 9'h099};
      TY_35_HD_INV:      return {7'd86, 9'h1B9};
      TY_35_HD:          return {7'd86, 9'h0B9};
      TY_35_HD_INV_DUAL: return {7'd86, 9'h1BB};
      TY_35_3MODE:       return {7'd86, 9'h0BB};
      TY_35_ED:          return {7'd86, 9'h0F9};
      default:           return '0;
    endcase
  endfunction

  function automatic logic [TrackW-1:0] clamp_track(input int t, input int mx);
    if (t < 0) t = 0;
    if (t > mx) t = mx;
    return t[TrackW-1:0];
  endfunction

  // Apply one command to the mirror and return the status the drive reports.
  function automatic fdm_out_t drive_status_after(input fdm_in_t it);
    fdm_out_t         st;
    logic [FlagW-1:0] fl;
    int               mx;
    int               diff;
    logic [SelW-1:0]  d;
    st   = '0;
    d    = it.drive_sel;
    diff = $signed(it.track_step);
    // density line is shared, so it moves even for an absent drive
    if (it.command == CMD_DENSITY) mirror_den = it.density_value;
    if (int'(d) >= NumDrives) return st;
    {mx, fl} = {25'd0, type_caps(mirror_type[d])};
    mx = int'(type_caps(mirror_type[d]) >> FlagW);
    case (it.command)
      CMD_STEP: begin
        if (diff != 0) begin
          mirror_track[d] = clamp_track(int'(mirror_track[d]) + diff, mx);
          mirror_chg[d]   = 1'b0;
        end
      end
      CMD_INSERT: begin
        mirror_track[d] = clamp_track(int'(mirror_track[d]), mx);
        mirror_chg[d]   = 1'b1;
      end
      CMD_HEAD: mirror_head[d] = it.head_value & fl[FDs];
      default: ;
    endcase
    st.track_now     = mirror_track[d];
    st.at_track_zero = (mx != 0) && (mirror_track[d] == '0);
    st.head_now      = fl[FDs] & mirror_head[d];
    if (!fl[FRpm360])                 st.speed_360 = 1'b0;
    else if (!fl[FRpm300])            st.speed_360 = 1'b1;
    else if (fl[F525])                st.speed_360 = mirror_den;
    else if (it.media_hole == HOLE_HD) st.speed_360 = ~mirror_den;
    else                              st.speed_360 = 1'b0;
    case (it.media_hole)
      HOLE_DD: st.medium_readable = fl[FHoleDd];
      HOLE_HD: st.medium_readable = fl[FHoleHd];
      HOLE_ED: st.medium_readable = fl[FHoleEd];
      default: st.medium_readable = 1'b0;
    endcase
    st.double_step   = fl[FDstep];
    st.drive_density = mirror_den ^ fl[FInvDen];
    st.disk_changed  = mirror_chg[d];
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // Result side back-pressure, changed on the falling edge.
  initial begin
    int hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni || quiet) begin
        hold        = 0;
        out_stall_i = 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
        if ($urandom_range(0, 99) < 25) hold = gap_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted status beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic note_field(input string fname, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  fdm_out_t want_st;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected status beat expected none actual %h", $time, out_data_o);
      end else begin
        want_st = pending_status.pop_front();
        note_field("track_now",       want_st.track_now,       out_data_o.track_now);
        note_field("at_track_zero",   want_st.at_track_zero,   out_data_o.at_track_zero);
        note_field("head_now",        want_st.head_now,        out_data_o.head_now);
        note_field("speed_360",       want_st.speed_360,       out_data_o.speed_360);
        note_field("medium_readable", want_st.medium_readable, out_data_o.medium_readable);
        note_field("double_step",     want_st.double_step,     out_data_o.double_step);
        note_field("drive_density",   want_st.drive_density,   out_data_o.drive_density);
        note_field("disk_changed",    want_st.disk_changed,    out_data_o.disk_changed);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends on a falling edge.
  // ---------------------------------------------------------------------------
  function automatic fdm_in_t cmd_beat(input logic [2:0] cmd, input logic [SelW-1:0] drv,
                                       input int step, input logic hd, input logic dn,
                                       input logic [1:0] hole);
    fdm_in_t it;
    it.command       = cmd;
    it.drive_sel     = drv;
    it.track_step    = step[7:0];
    it.head_value    = hd;
    it.density_value = dn;
    it.media_hole    = hole;
    return it;
  endfunction

  // Send one command beat; valid stays up across back-to-back beats.
  task automatic issue_cmd(input fdm_in_t it);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_status.push_back(drive_status_after(it));
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every owed status beat is back.
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_status.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_type(input logic [CfgIdxW-1:0] idx, input logic [TypeW-1:0] ty);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = ty;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mirror_type[idx] = ty;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_types(input logic [TypeW-1:0] ta, input logic [TypeW-1:0] tb,
                           input logic [TypeW-1:0] tc, input logic [TypeW-1:0] td);
    settle();
    write_type(REG_TYPE_A, ta);
    write_type(REG_TYPE_B, tb);
    write_type(REG_TYPE_C, tc);
    write_type(REG_TYPE_D, td);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // all bays empty after reset: status is all zero, no track-0 on type none
  task automatic test_reset_state();
    issue_cmd(cmd_beat(CMD_STATUS, DRV_A, 0, 1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_STATUS, DRV_B, 0, 1'b0, 1'b0, HOLE_HD));
    issue_cmd(cmd_beat(CMD_STATUS, DRV_C, 0, 1'b0, 1'b0, HOLE_ED));
    issue_cmd(cmd_beat(CMD_STATUS, DRV_D, 0, 1'b0, 1'b0, HOLE_BAD));
  endtask

  // step clamping at both ends, zero step, insert sets changed, real step clears
  task automatic test_step_and_insert();
    set_types(TY_525_2QD, TY_525_1DD, TY_35_ED, TY_SPARE_15);
    issue_cmd(cmd_beat(CMD_STEP,   DRV_A, 127,  1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_STEP,   DRV_A, -128, 1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_STEP,   DRV_A, 0,    1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_INSERT, DRV_A, 55,   1'b0, 1'b0, HOLE_ED));
    issue_cmd(cmd_beat(CMD_STEP,   DRV_A, 0,    1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_STEP,   DRV_A, 1,    1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_STEP,   DRV_B, 127,  1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_STEP,   DRV_D, 5,    1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_INSERT, DRV_D, 0,    1'b0, 1'b0, HOLE_HD));
  endtask

  // head forced to 0 on single-sided, density line and media readability
  task automatic test_head_and_density();
    issue_cmd(cmd_beat(CMD_HEAD,    DRV_B, 0, 1'b1, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_HEAD,    DRV_A, 0, 1'b1, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_HEAD,    DRV_C, 0, 1'b1, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_DENSITY, DRV_A, 0, 1'b0, 1'b1, HOLE_DD));
    issue_cmd(cmd_beat(CMD_STATUS,  DRV_C, 0, 1'b0, 1'b0, HOLE_HD));
    issue_cmd(cmd_beat(CMD_STATUS,  DRV_C, 0, 1'b0, 1'b0, HOLE_ED));
    issue_cmd(cmd_beat(CMD_STATUS,  DRV_C, 0, 1'b0, 1'b0, HOLE_BAD));
    issue_cmd(cmd_beat(CMD_DENSITY, DRV_C, 0, 1'b0, 1'b0, HOLE_HD));
  endtask

  // type swapped under a parked head: track kept until the next insert clamps
  task automatic test_type_change();
    issue_cmd(cmd_beat(CMD_STEP, DRV_A, 127, 1'b0, 1'b0, HOLE_DD));
    settle();
    write_type(REG_TYPE_A, TY_525_1DD);
    issue_cmd(cmd_beat(CMD_STATUS,  DRV_A, 0, 1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_INSERT,  DRV_A, 0, 1'b0, 1'b0, HOLE_DD));
    issue_cmd(cmd_beat(CMD_SPARE_5, DRV_A, 9, 1'b1, 1'b1, HOLE_HD));
    issue_cmd(cmd_beat(CMD_SPARE_6, DRV_A, 9, 1'b1, 1'b1, HOLE_HD));
    issue_cmd(cmd_beat(CMD_SPARE_7, DRV_A, 9, 1'b1, 1'b1, HOLE_HD));
  endtask

  // Random command: mostly short head moves so tracks wander the whole range.
  function automatic fdm_in_t rand_beat();
    fdm_in_t it;
    int      r;
    int      step;
    r = $urandom_range(0, 99);
    if (r < 10)      step = 0;
    else if (r < 65) step = int'($urandom_range(0, 20)) - 10;
    else             step = $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    if (r < 40)      it.command = CMD_STEP;
    else if (r < 52) it.command = CMD_INSERT;
    else if (r < 64) it.command = CMD_HEAD;
    else if (r < 78) it.command = CMD_DENSITY;
    else if (r < 95) it.command = CMD_STATUS;
    else             it.command = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
    it.drive_sel     = SelW'($urandom_range(0, NumDrives - 1));
    it.track_step    = step[7:0];
    it.head_value    = 1'($urandom_range(0, 1));
    it.density_value = 1'($urandom_range(0, 1));
    it.media_hole    = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic logic [TypeW-1:0] rand_type();
    if ($urandom_range(0, 99) < 85) return TypeW'($urandom_range(TY_525_1DD, TY_35_ED));
    return TypeW'($urandom_range(TY_SPARE_14, TY_SPARE_15));
  endfunction

  // phases of random traffic, each under its own type setting
  task automatic test_random_traffic();
    for (int p = 0; p < 12; p++) begin
      case (p)
        0:       set_types(TY_35_ED, TY_35_ED, TY_35_ED, TY_35_ED);
        1:       set_types(TY_NONE, TY_NONE, TY_NONE, TY_NONE);
        2:       set_types(TY_SPARE_15, TY_SPARE_14, TY_NONE, TY_35_ED);
        3:       set_types(TY_525_HD_INV, TY_525_HD_DUAL, TY_35_HD_INV_DUAL, TY_35_3MODE);
        default: set_types(rand_type(), rand_type(), rand_type(), rand_type());
      endcase
      quiet = (p == 4 || p == 8);
      repeat (125) issue_cmd(rand_beat());
      quiet = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    for (int i = 0; i < NumDrives; i++) begin
      mirror_track[i] = '0;
      mirror_head[i]  = 1'b0;
      mirror_chg[i]   = 1'b0;
    end
    for (int i = 0; i < 4; i++) mirror_type[i] = TY_NONE;
    mirror_den = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_step_and_insert();
    test_head_and_density();
    test_type_change();
    test_random_traffic();

    settle();
    // the extra edges below catch any stray beat
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("floppy_drive_mechanism_tb: clean");
    end else begin
      $display("floppy_drive_mechanism_tb: errors");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("floppy_drive_mechanism_tb: errors");
    $finish;
  end

endmodule
